@@ hw/rtl/decimal_seven_segment_writer_assert.svh @@
// assertion macros for the port-level checker file
`ifndef DECIMAL_SEVEN_SEGMENT_WRITER_ASSERT_SVH
`define DECIMAL_SEVEN_SEGMENT_WRITER_ASSERT_SVH

// concurrent check, masked while reset is asserted
`define DSSW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dssw assertion failed");

// concurrent check that also holds during reset
`define DSSW_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("dssw assertion failed during reset");

`endif

@@ hw/rtl/dssw_pkg.sv @@
// shared constants, types and the digit code table of the decimal display writer
`default_nettype none

package dssw_pkg;

	localparam int NUM_POSITIONS = 8;
	localparam int POS_W         = $clog2(NUM_POSITIONS);
	localparam int CNT_W         = $clog2(NUM_POSITIONS + 2);
	localparam int SEG_W         = 7;
	localparam int VAL_W         = 27;
	localparam int DIG_W         = 4;

	// divide by ten as multiply by reciprocal, exact for any 32-bit dividend
	localparam int          RECIP_W     = 32;
	localparam int          RECIP_SHIFT = 35;
	localparam int          PROD_W      = VAL_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

	typedef enum logic {
		OP_SHOW  = 1'b0,
		OP_BLANK = 1'b1
	} op_t;

	// seven-segment code, bit0 segment a through bit6 segment g
	function automatic logic [SEG_W-1:0] seg_code(input logic [DIG_W-1:0] dig);
		logic [SEG_W-1:0] code;
		case (dig)
			4'd0:    code = 7'b0111111;
			4'd1:    code = 7'b0000110;
			4'd2:    code = 7'b1011011;
			4'd3:    code = 7'b1001111;
			4'd4:    code = 7'b1100110;
			4'd5:    code = 7'b1101101;
			4'd6:    code = 7'b1111101;
			4'd7:    code = 7'b0000111;
			4'd8:    code = 7'b1111111;
			4'd9:    code = 7'b1100111;
			default: code = '0;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dssw_if.sv @@
// valid/ready channel interfaces for the request and the display write items
`default_nettype none

interface dssw_req_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [dssw_pkg::POS_W-1:0] start_position;
	logic [dssw_pkg::VAL_W-1:0] value;

	modport source (output valid, output operation, output start_position, output value,
		input ready);
	modport sink (input valid, input operation, input start_position, input value,
		output ready);
endinterface

interface dssw_wr_if;
	logic                       valid;
	logic                       ready;
	logic [dssw_pkg::POS_W-1:0] position;
	logic [dssw_pkg::SEG_W-1:0] segments;
	logic                       last;

	modport source (output valid, output position, output segments, output last,
		input ready);
	modport sink (input valid, input position, input segments, input last,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/decimal_seven_segment_writer.sv @@
// decimal display writer: binary value to per-position seven-segment writes
//
//   port   dir    item contents
//   din    sink   operation, start_position, value
//   dout   source position, segments, last
//
// show: each decimal digit passes through one shared divide-by-ten unit
// (multiply by reciprocal, then remainder) and is then written, one write per
// cycle unless the sink stalls; a value that does not fit stops early. blank:
// 8 writes, one per cycle unless stalled. din.ready is high only between items.
// dout is a registered output stage; a stalled sink holds the sequencer in place.
// arst_n clears the sequencer and the output valid at once.
`default_nettype none

module decimal_seven_segment_writer (
	input  wire           clk,
	input  wire           arst_n,
	dssw_req_if.sink      din,
	dssw_wr_if.source     dout
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_REM  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                          state_q;
	logic                            blank_q;
	logic [dssw_pkg::CNT_W-1:0]      cnt_q;
	logic [dssw_pkg::CNT_W-1:0]      idx_q;
	logic [dssw_pkg::POS_W-1:0]      start_q;
	logic [dssw_pkg::VAL_W-1:0]      val_q;
	logic [dssw_pkg::PROD_W-1:0]     prod_q;
	logic [dssw_pkg::DIG_W-1:0]      dig_q [dssw_pkg::NUM_POSITIONS];

	logic                            ovalid_q;
	logic [dssw_pkg::POS_W-1:0]      opos_q;
	logic [dssw_pkg::SEG_W-1:0]      oseg_q;
	logic                            olast_q;

	logic                            in_acc;
	logic                            emit_go;
	logic                            emit_last;
	logic [dssw_pkg::VAL_W-1:0]      quo;
	logic [dssw_pkg::VAL_W-1:0]      rem_full;
	logic [dssw_pkg::DIG_W-1:0]      digit;
	logic [dssw_pkg::CNT_W-1:0]      cnt_nx;
	logic                            fits;
	logic [dssw_pkg::POS_W-1:0]      idx_pos;

	assign din.ready = (state_q == ST_IDLE);
	assign in_acc    = din.valid && din.ready;

	// shared divide-by-ten unit, second half: quotient, remainder and fit check
	always_comb begin
		quo      = dssw_pkg::VAL_W'(prod_q[dssw_pkg::PROD_W-1:dssw_pkg::RECIP_SHIFT]);
		rem_full = val_q - ((quo << 3) + (quo << 1));
		digit    = rem_full[dssw_pkg::DIG_W-1:0];
		cnt_nx   = cnt_q + dssw_pkg::CNT_W'(1);
		fits     = ((dssw_pkg::CNT_W + 1)'(start_q) + (dssw_pkg::CNT_W + 1)'(cnt_nx))
			<= (dssw_pkg::CNT_W + 1)'(dssw_pkg::NUM_POSITIONS);
	end

	// write emission when the output stage is free
	assign emit_go   = (state_q == ST_EMIT) && (!ovalid_q || dout.ready);
	assign emit_last = (idx_q + dssw_pkg::CNT_W'(1)) == cnt_q;
	assign idx_pos   = idx_q[dssw_pkg::POS_W-1:0];

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			blank_q  <= 1'b0;
			cnt_q    <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				ovalid_q <= 1'b1;
			end else if (dout.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q <= '0;
						if (din.operation == dssw_pkg::OP_BLANK) begin
							blank_q <= 1'b1;
							cnt_q   <= dssw_pkg::CNT_W'(dssw_pkg::NUM_POSITIONS);
							state_q <= ST_EMIT;
						end else begin
							blank_q <= 1'b0;
							cnt_q   <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					cnt_q <= cnt_nx;
					if (!fits) begin
						state_q <= ST_IDLE;
					end else if (quo == '0) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						idx_q <= idx_q + dssw_pkg::CNT_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: operand, product, digit store and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_q <= din.start_position;
			val_q   <= din.value;
		end
		if (state_q == ST_MUL) begin
			prod_q <= val_q * dssw_pkg::RECIP_10;
		end
		if (state_q == ST_REM) begin
			dig_q[cnt_q[dssw_pkg::POS_W-1:0]] <= digit;
			val_q <= quo;
		end
		if (emit_go) begin
			olast_q <= emit_last;
			if (blank_q) begin
				opos_q <= idx_pos;
				oseg_q <= '0;
			end else begin
				opos_q <= start_q + idx_pos;
				oseg_q <= dssw_pkg::seg_code(dig_q[idx_pos]);
			end
		end
	end

	assign dout.valid    = ovalid_q;
	assign dout.position = opos_q;
	assign dout.segments = oseg_q;
	assign dout.last     = olast_q;

endmodule

`default_nettype wire

@@ hw/rtl/dssw_checker.sv @@
// port-level checks of the decimal display writer and their bind
`default_nettype none

`include "decimal_seven_segment_writer_assert.svh"

module dssw_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       in_valid,
	input wire                       in_ready,
	input wire                       out_valid,
	input wire                       out_ready,
	input wire [dssw_pkg::POS_W-1:0] out_position,
	input wire                       out_last
);

	// a pending write is not withdrawn
	`DSSW_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)

	// an accepted request makes the block busy in the next cycle
	`DSSW_ASSERT(a_busy_after_acc, clk, arst_n, in_valid && in_ready |=> !in_ready)

	// writes of one run come back to back and at rising positions
	`DSSW_ASSERT(a_run_contig, clk, arst_n,
		out_valid && out_ready && !out_last |=> out_valid)
	`DSSW_ASSERT(a_run_pos, clk, arst_n,
		out_valid && out_ready && !out_last
		|=> out_position == $past(out_position) + dssw_pkg::POS_W'(1))

	// no write is shown while reset is asserted
	`DSSW_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !out_valid)

endmodule

bind decimal_seven_segment_writer dssw_checker u_dssw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (din.valid),
	.in_ready     (din.ready),
	.out_valid    (dout.valid),
	.out_ready    (dout.ready),
	.out_position (dout.position),
	.out_last     (dout.last)
);

`default_nettype wire

@@ test/decimal_seven_segment_writer_tb.sv @@
// self-checking testbench for the decimal seven-segment display writer
`default_nettype none

module decimal_seven_segment_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int RANDOM_ITEMS  = 200;
	localparam int MAX_WAIT      = 6;
	// an 8-digit value goes through all its divide steps before its first write
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 400000;

	// digit glyphs, bit0 segment a through bit6 segment g
	localparam logic [dssw_pkg::SEG_W-1:0] DIGIT_GLYPH [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
	};
	localparam logic [dssw_pkg::SEG_W-1:0] GLYPH_BLANK = '0;
	localparam logic [dssw_pkg::SEG_W-1:0] GLYPH_ZERO  = 7'h3F;
	localparam logic [dssw_pkg::SEG_W-1:0] GLYPH_ONE   = 7'h06;
	localparam logic [dssw_pkg::SEG_W-1:0] GLYPH_EIGHT = 7'h7F;
	localparam logic [dssw_pkg::SEG_W-1:0] GLYPH_NINE  = 7'h67;

	typedef struct packed {
		logic [dssw_pkg::POS_W-1:0] position;
		logic [dssw_pkg::SEG_W-1:0] segments;
		logic                       last;
	} display_write_t;

	// one request; typed rows carry n_writes copies of glyph from first_pos upward
	typedef struct {
		dssw_pkg::op_t              op;
		logic [dssw_pkg::POS_W-1:0] start;
		logic [dssw_pkg::VAL_W-1:0] value;
		bit                         typed;
		int unsigned                n_writes;
		logic [dssw_pkg::POS_W-1:0] first_pos;
		logic [dssw_pkg::SEG_W-1:0] glyph;
	} request_row_t;

	request_row_t request_rows [18] = '{
		'{dssw_pkg::OP_BLANK, 3'd0, 27'd0,         1'b1, 8, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd0, 27'd0,         1'b1, 1, 3'd0, GLYPH_ZERO},
		'{dssw_pkg::OP_SHOW,  3'd7, 27'd0,         1'b1, 1, 3'd7, GLYPH_ZERO},
		'{dssw_pkg::OP_SHOW,  3'd0, 27'd99999999,  1'b1, 8, 3'd0, GLYPH_NINE},
		'{dssw_pkg::OP_SHOW,  3'd1, 27'd99999999,  1'b1, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd0, 27'h7FFFFFF,   1'b1, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd0, 27'd88888888,  1'b1, 8, 3'd0, GLYPH_EIGHT},
		'{dssw_pkg::OP_SHOW,  3'd7, 27'd9,         1'b1, 1, 3'd7, GLYPH_NINE},
		'{dssw_pkg::OP_SHOW,  3'd7, 27'd10,        1'b1, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_BLANK, 3'd7, 27'h7FFFFFF,   1'b1, 8, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd3, 27'd1,         1'b1, 1, 3'd3, GLYPH_ONE},
		'{dssw_pkg::OP_SHOW,  3'd0, 27'd12345678,  1'b0, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd1, 27'd1234567,   1'b0, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd2, 27'd1234567,   1'b1, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd0, 27'd76543210,  1'b0, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd1, 27'd1000000,   1'b0, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd0, 27'h5555555,   1'b0, 0, 3'd0, GLYPH_BLANK},
		'{dssw_pkg::OP_SHOW,  3'd0, 27'h2AAAAAA,   1'b0, 0, 3'd0, GLYPH_BLANK}
	};

	logic clk;
	logic arst_n;
	bit   steady;
	int   error_count;
	int   cycle_count;

	display_write_t expected_writes [$];

	dssw_req_if din_bus ();
	dssw_wr_if  dout_bus ();

	decimal_seven_segment_writer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_bus.sink),
		.dout   (dout_bus.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// writes a request should cause, pushed in display order
	function automatic void predict_writes(dssw_pkg::op_t op,
		logic [dssw_pkg::POS_W-1:0] start, logic [dssw_pkg::VAL_W-1:0] val);
		int unsigned    digits;
		int unsigned    rest;
		int unsigned    pos;
		display_write_t w;
		if (op == dssw_pkg::OP_BLANK) begin
			for (pos = 0; pos < dssw_pkg::NUM_POSITIONS; pos++) begin
				w.position = pos[dssw_pkg::POS_W-1:0];
				w.segments = GLYPH_BLANK;
				w.last     = (pos == dssw_pkg::NUM_POSITIONS - 1);
				expected_writes.push_back(w);
			end
			return;
		end
		digits = 1;
		rest   = 32'(val);
		while (rest >= 10) begin
			rest /= 10;
			digits++;
		end
		if (start + digits > dssw_pkg::NUM_POSITIONS)
			return;
		rest = 32'(val);
		pos  = 32'(start);
		do begin
			w.position = pos[dssw_pkg::POS_W-1:0];
			w.segments = DIGIT_GLYPH[rest % 10];
			rest /= 10;
			w.last     = (rest == 0);
			expected_writes.push_back(w);
			pos++;
		end while (rest > 0);
	endfunction

	// writes typed straight into a directed row
	function automatic void push_typed_writes(request_row_t row);
		display_write_t w;
		for (int unsigned i = 0; i < row.n_writes; i++) begin
			w.position = row.first_pos + i[dssw_pkg::POS_W-1:0];
			w.segments = row.glyph;
			w.last     = (i == row.n_writes - 1);
			expected_writes.push_back(w);
		end
	endfunction

	// random value with exactly n decimal digits
	function automatic logic [dssw_pkg::VAL_W-1:0] value_with_digits(int unsigned n);
		int unsigned lo;
		int unsigned hi;
		lo = 1;
		for (int unsigned i = 1; i < n; i++)
			lo *= 10;
		hi = lo * 10 - 1;
		if (n == 1)
			lo = 0;
		return dssw_pkg::VAL_W'($urandom_range(lo, hi));
	endfunction

	// offer one item after a random gap (none while steady); returns at the edge that takes it
	task automatic send_request(dssw_pkg::op_t op, logic [dssw_pkg::POS_W-1:0] start,
		logic [dssw_pkg::VAL_W-1:0] val);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			din_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_bus.valid          <= 1'b1;
		din_bus.operation      <= op;
		din_bus.start_position <= start;
		din_bus.value          <= val;
		do @(posedge clk); while (!din_bus.ready);
	endtask

	// hold off new items until the display writes are all out
	task automatic drain_writes();
		din_bus.valid <= 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stimulus
	initial begin
		request_row_t row;
		int           kind;
		int unsigned  n;
		arst_n                 = 1'b0;
		steady                 = 1'b0;
		error_count            = 0;
		din_bus.valid          = 1'b0;
		din_bus.operation      = dssw_pkg::OP_SHOW;
		din_bus.start_position = '0;
		din_bus.value          = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (request_rows[i]) begin
			row = request_rows[i];
			send_request(row.op, row.start, row.value);
			if (row.typed)
				push_typed_writes(row);
			else
				predict_writes(row.op, row.start, row.value);
		end

		// random requests, mostly values that fit
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 80 && i < 120);
			if (i == 150)
				drain_writes();
			kind = $urandom_range(0, 9);
			row.op    = dssw_pkg::OP_SHOW;
			row.start = dssw_pkg::POS_W'($urandom_range(0, dssw_pkg::NUM_POSITIONS - 1));
			row.value = dssw_pkg::VAL_W'($urandom_range(0, 2 ** dssw_pkg::VAL_W - 1));
			if (kind == 0) begin
				row.op = dssw_pkg::OP_BLANK;
			end else if (kind <= 7) begin
				n         = $urandom_range(1, dssw_pkg::NUM_POSITIONS);
				row.start = dssw_pkg::POS_W'($urandom_range(0, dssw_pkg::NUM_POSITIONS - n));
				row.value = value_with_digits(n);
			end else if (kind == 8) begin
				row.start = dssw_pkg::POS_W'($urandom_range(1, dssw_pkg::NUM_POSITIONS - 1));
				n         = $urandom_range(dssw_pkg::NUM_POSITIONS - row.start + 1,
					dssw_pkg::NUM_POSITIONS);
				row.value = value_with_digits(n);
			end
			send_request(row.op, row.start, row.value);
			predict_writes(row.op, row.start, row.value);
		end
		steady = 1'b0;
		drain_writes();

		if (error_count == 0 && expected_writes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// sink side ready with random stalls, none while steady
	initial begin
		int stall;
		dout_bus.ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				dout_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_bus.ready <= 1'b1;
			do @(posedge clk); while (!dout_bus.valid);
		end
	end

	// compare each accepted write with the oldest expectation
	always @(posedge clk) begin : write_check
		display_write_t got;
		display_write_t want;
		if (arst_n && dout_bus.valid && dout_bus.ready) begin
			got.position = dout_bus.position;
			got.segments = dout_bus.segments;
			got.last     = dout_bus.last;
			if (expected_writes.size() == 0) begin
				error_count++;
				$display("%0t: unexpected write: pos %0d seg %b last %b",
					$time, got.position, got.segments, got.last);
			end else begin
				want = expected_writes.pop_front();
				if (got.position !== want.position || got.segments !== want.segments ||
					got.last !== want.last) begin
					error_count++;
					$display("%0t: write mismatch: expected pos %0d seg %b last %b,",
						$time, want.position, want.segments, want.last,
						" got pos %0d seg %b last %b",
						got.position, got.segments, got.last);
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d writes outstanding", $time, expected_writes.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
